### rtl/dmlc_pkg.sv
`default_nettype none
// ---------------------------------------------------------------------------
// dmlc_pkg
// Types and constants of the direct-mapped line cache.
// ---------------------------------------------------------------------------
package dmlc_pkg;

    localparam int LINES      = 16;   // power of two
    localparam int IDX_W      = $clog2(LINES);
    localparam int LINE_BYTES = 16;
    localparam int LINE_W     = 8 * LINE_BYTES;
    localparam int ADDR_W     = 32;
    localparam int OFS_W      = $clog2(LINE_BYTES);
    localparam int TAG_W      = ADDR_W - OFS_W;
    localparam int LEN_W      = 5;
    localparam int HALF_W     = 64;

    localparam logic [LEN_W-1:0] MAX_LEN = LEN_W'(LINE_BYTES);

    typedef enum logic [1:0] {
        OP_READ  = 2'd0,
        OP_FILL  = 2'd1,
        OP_INVAL = 2'd2
    } t_op;

    function automatic logic [LEN_W-1:0] sat_len(input logic [LEN_W-1:0] len);
        sat_len = (len > MAX_LEN) ? MAX_LEN : len;
    endfunction

endpackage
`default_nettype wire

### rtl/dmlc_ram.sv
`default_nettype none
// ---------------------------------------------------------------------------
// dmlc_ram
// Simple dual-port RAM: one write port, one read port with registered data.
// ---------------------------------------------------------------------------
module dmlc_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16,
    parameter int AW    = $clog2(DEPTH)
) (
    input  wire logic             i_clk,
    input  wire logic             i_we,
    input  wire logic [AW-1:0]    i_waddr,
    input  wire logic [WIDTH-1:0] i_wdata,
    input  wire logic             i_re,
    input  wire logic [AW-1:0]    i_raddr,
    output logic      [WIDTH-1:0] o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_re) begin
            o_rdata <= r_mem[i_raddr];
        end
    end

endmodule
`default_nettype wire

### rtl/direct_mapped_line_cache.sv
`default_nettype none
// ---------------------------------------------------------------------------
// direct_mapped_line_cache
// Direct-mapped cache of 16-byte lines: read lookup, line fill, invalidate.
// ---------------------------------------------------------------------------
// Usage:
//   Input channel i_valid / o_stall carries one word per access: op, addr,
//   read_len, write_len and the 16 fill bytes. Output channel o_valid /
//   i_stall returns one word per access: hit, line_low, line_high.
//   A word is taken at a rising edge with valid high and stall low.
//   The tag and line RAMs are read at the accept edge; when the lookup
//   stage fires, the lookup, byte merge and (for a fill) RAM write-back
//   are done and the result register is loaded. One access is accepted
//   every cycle while the receiver does not stall; a fill followed at
//   once by an access to the same line is served from a bypass register,
//   so back-to-back traffic to one line never waits on the RAM.
//   Reset clears the line-valid and line-used flags; no RAM clearing
//   pass is made (a line never filled reads as zero bytes).
//   When the receiver stalls, the result register holds, one more access
//   is taken into the lookup stage, and then o_stall rises until the
//   result is taken.
// ---------------------------------------------------------------------------
module direct_mapped_line_cache
    import dmlc_pkg::*;
(
    input  wire logic              i_clk,
    input  wire logic              i_rst_n,
    input  wire logic              i_valid,
    output logic                   o_stall,
    input  wire logic [1:0]        i_op,
    input  wire logic [ADDR_W-1:0] i_addr,
    input  wire logic [LEN_W-1:0]  i_read_len,
    input  wire logic [LEN_W-1:0]  i_write_len,
    input  wire logic [HALF_W-1:0] i_fill_low,
    input  wire logic [HALF_W-1:0] i_fill_high,
    output logic                   o_valid,
    input  wire logic              i_stall,
    output logic                   o_hit,
    output logic      [HALF_W-1:0] o_line_low,
    output logic      [HALF_W-1:0] o_line_high
);

    // lookup stage
    logic              r_v1;
    logic [1:0]        r_op;
    logic [TAG_W-1:0]  r_tag;
    logic [LEN_W-1:0]  r_rlen;
    logic [LEN_W-1:0]  r_wlen;
    logic [HALF_W-1:0] r_fill_low;
    logic [HALF_W-1:0] r_fill_high;
    logic              r_byp;
    logic [LINE_W-1:0] r_byp_line;
    logic [TAG_W-1:0]  r_byp_tag;

    logic              r_line_valid [LINES];
    logic              r_line_used  [LINES];

    // result register
    logic              r_out_v;
    logic              r_hit;
    logic [HALF_W-1:0] r_lo;
    logic [HALF_W-1:0] r_hi;

    logic              w_accept;
    logic              w_fire;
    logic [IDX_W-1:0]  w_idx_in;
    logic [IDX_W-1:0]  w_idx;
    logic [LINE_W-1:0] w_ram_line;
    logic [TAG_W-1:0]  w_ram_tag;
    logic [LINE_W-1:0] w_old_line;
    logic [TAG_W-1:0]  w_old_tag;
    logic [LINE_W-1:0] w_fill;
    logic [LINE_W-1:0] w_new_line;
    logic [LINE_W-1:0] w_rd_line;
    logic [LEN_W-1:0]  w_rlen;
    logic [LEN_W-1:0]  w_wlen;
    logic              w_hit;
    logic              w_is_fill;
    logic              w_is_read;
    logic              w_is_inval;

    assign w_fire   = r_v1 && (!r_out_v || !i_stall);
    assign o_stall  = r_v1 && !w_fire;
    assign w_accept = i_valid && !o_stall;
    assign w_idx_in = i_addr[OFS_W +: IDX_W];
    assign w_idx    = r_tag[IDX_W-1:0];

    assign w_is_read  = (r_op == OP_READ);
    assign w_is_fill  = (r_op == OP_FILL);
    assign w_is_inval = (r_op == OP_INVAL);

    dmlc_ram #(.WIDTH(LINE_W), .DEPTH(LINES)) u_line_ram (
        .i_clk   (i_clk),
        .i_we    (w_fire && w_is_fill),
        .i_waddr (w_idx),
        .i_wdata (w_new_line),
        .i_re    (w_accept),
        .i_raddr (w_idx_in),
        .o_rdata (w_ram_line)
    );

    dmlc_ram #(.WIDTH(TAG_W), .DEPTH(LINES)) u_tag_ram (
        .i_clk   (i_clk),
        .i_we    (w_fire && w_is_fill),
        .i_waddr (w_idx),
        .i_wdata (r_tag),
        .i_re    (w_accept),
        .i_raddr (w_idx_in),
        .o_rdata (w_ram_tag)
    );

    assign w_old_line = r_byp ? r_byp_line : w_ram_line;
    assign w_old_tag  = r_byp ? r_byp_tag  : w_ram_tag;
    assign w_hit      = r_line_valid[w_idx] && (w_old_tag == r_tag);
    assign w_rlen     = sat_len(r_rlen);
    assign w_wlen     = sat_len(r_wlen);
    assign w_fill     = {r_fill_high, r_fill_low};

    always_comb begin
        w_new_line = '0;
        w_rd_line  = '0;
        for (int b = 0; b < LINE_BYTES; b++) begin
            if (LEN_W'(b) < w_wlen) begin
                w_new_line[8*b +: 8] = w_fill[8*b +: 8];
            end else if (r_line_used[w_idx]) begin
                w_new_line[8*b +: 8] = w_old_line[8*b +: 8];
            end
            if (LEN_W'(b) < w_rlen) begin
                w_rd_line[8*b +: 8] = w_old_line[8*b +: 8];
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v1  <= 1'b0;
            r_byp <= 1'b0;
        end else begin
            r_v1 <= w_accept || (r_v1 && !w_fire);
            if (w_accept) begin
                r_byp <= w_fire && w_is_fill && (w_idx_in == w_idx);
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_accept) begin
            r_op        <= i_op;
            r_tag       <= i_addr[ADDR_W-1:OFS_W];
            r_rlen      <= i_read_len;
            r_wlen      <= i_write_len;
            r_fill_low  <= i_fill_low;
            r_fill_high <= i_fill_high;
            r_byp_line  <= w_new_line;
            r_byp_tag   <= r_tag;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int k = 0; k < LINES; k++) begin
                r_line_valid[k] <= 1'b0;
                r_line_used[k]  <= 1'b0;
            end
        end else if (w_fire) begin
            if (w_is_fill) begin
                r_line_valid[w_idx] <= 1'b1;
                r_line_used[w_idx]  <= 1'b1;
            end else if (w_is_inval && w_hit) begin
                r_line_valid[w_idx] <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_v <= 1'b0;
        end else begin
            r_out_v <= w_fire || (r_out_v && i_stall);
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_fire) begin
            r_hit <= w_hit;
            if (w_is_read && w_hit) begin
                r_lo <= w_rd_line[HALF_W-1:0];
                r_hi <= w_rd_line[LINE_W-1:HALF_W];
            end else begin
                r_lo <= '0;
                r_hi <= '0;
            end
        end
    end

    assign o_valid     = r_out_v;
    assign o_hit       = r_hit;
    assign o_line_low  = r_lo;
    assign o_line_high = r_hi;

    a_fill_sets_valid: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (w_fire && w_is_fill) |=> r_line_valid[$past(w_idx)])
        else $error("fill did not set line valid");

    a_inval_clears: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (w_fire && w_is_inval && w_hit) |=> !r_line_valid[$past(w_idx)])
        else $error("invalidate hit left line valid");

    a_byp_source: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $rose(r_byp) |-> $past(w_fire && w_is_fill && w_accept))
        else $error("bypass set without a fill in flight");

    a_out_from_fire: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $rose(o_valid) |-> $past(w_fire))
        else $error("result appeared without a lookup");

endmodule
`default_nettype wire
